// ----- sv/pald_pkg.sv -----
// shared constants for the point-along-line datapath
package pald_pkg;

	// default coordinate width, signed fixed point with 16 fraction bits
	localparam int COORD_WIDTH = 32;

	// extra fraction bits carried on the axis length
	localparam int EXTRA_BITS = 14;

endpackage

// ----- sv/pald_in_if.sv -----
// input channel: origin and axis points
interface pald_in_if #(
	parameter int W = pald_pkg::COORD_WIDTH
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] origin_x;
	logic signed [W-1:0] origin_y;
	logic signed [W-1:0] origin_z;
	logic signed [W-1:0] axis_x;
	logic signed [W-1:0] axis_y;
	logic signed [W-1:0] axis_z;

	modport source (
		output valid, origin_x, origin_y, origin_z, axis_x, axis_y, axis_z,
		input  ready
	);
	modport sink (
		input  valid, origin_x, origin_y, origin_z, axis_x, axis_y, axis_z,
		output ready
	);
endinterface

// ----- sv/pald_out_if.sv -----
// output channel: result point and degenerate flag
interface pald_out_if #(
	parameter int W = pald_pkg::COORD_WIDTH
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] point_x;
	logic signed [W-1:0] point_y;
	logic signed [W-1:0] point_z;
	logic                degenerate;

	modport source (
		output valid, point_x, point_y, point_z, degenerate,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_z, degenerate,
		output ready
	);
endinterface

// ----- sv/point_at_distance_along_line.sv -----
// top level: point at a signed distance from an origin towards an axis point
//
// in_ch carries an origin and an axis point per transaction; out_ch returns
// origin + offset * (axis - origin) / |axis - origin|, each coordinate
// saturated, in signed fixed point with 16 fraction bits. the user writes
// offset via cfg_we / cfg_wdata only while the block is idle; unenforced.
// the datapath is three lanes, one per coordinate, feeding a shared
// squared-length sum and a pipelined square root; each lane then runs
// its own pipelined divider, and a merge stage builds the result.
// throughput: one transaction per cycle unless out_ch is stalling.
// between acceptance and out_ch.valid lie the square root (COORD_WIDTH + 15
// stages) and the divider (COORD_WIDTH + 2 stages), in series.
// coincident points give the origin back with degenerate set.
// the whole pipeline moves together: it advances unless a result is held
// in the output register and the receiver is stalling; while that result
// waits every stage freezes and in_ch.ready stays low.
// reset clears offset and every valid bit; data registers are not reset.
module point_at_distance_along_line #(
	parameter int COORD_WIDTH = pald_pkg::COORD_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [COORD_WIDTH-1:0] cfg_wdata,
	pald_in_if.sink                in_ch,
	pald_out_if.source             out_ch
);
	localparam int W   = COORD_WIDTH;
	localparam int EB  = pald_pkg::EXTRA_BITS;
	localparam int NW  = W + EB + 1;
	localparam int LAT = W + NW + 6;
	localparam int DG  = NW + W + 2;

	logic [W-1:0]        offset_q;
	logic [W-1:0]        offmag;
	logic                offneg;
	logic                en;
	logic                vld_q [LAT];

	logic [2*W-1:0]      sq_x;
	logic [2*W-1:0]      sq_y;
	logic [2*W-1:0]      sq_z;
	logic [2*W+1:0]      ssum;
	logic [2*NW-1:0]     rad_s3;
	logic                deg_s3;
	logic                deg_d [DG];
	logic [NW-1:0]       root;

	logic signed [W-1:0] pt_x;
	logic signed [W-1:0] pt_y;
	logic signed [W-1:0] pt_z;
	logic signed [W-1:0] org_x;
	logic signed [W-1:0] org_y;
	logic signed [W-1:0] org_z;

	logic signed [W-1:0] point_x_q;
	logic signed [W-1:0] point_y_q;
	logic signed [W-1:0] point_z_q;
	logic                deg_q;

	// offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	assign offneg = offset_q[W-1];
	assign offmag = offneg ? (~offset_q + 1'b1) : offset_q;

	// global advance: stop only when a held result is not taken
	assign en          = !vld_q[LAT-1] || out_ch.ready;
	assign in_ch.ready = en;

	for (genvar k = 0; k < LAT; k++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= (k == 0) ? in_ch.valid : vld_q[(k == 0) ? 0 : k-1];
			end
		end
	end

	// coordinate lanes
	pald_lane #(.W(W), .NW(NW)) u_lane_x (
		.clk   (clk),
		.en    (en),
		.origin(in_ch.origin_x),
		.axis  (in_ch.axis_x),
		.offmag(offmag),
		.offneg(offneg),
		.root  (root),
		.sq    (sq_x),
		.point (pt_x),
		.org   (org_x)
	);

	pald_lane #(.W(W), .NW(NW)) u_lane_y (
		.clk   (clk),
		.en    (en),
		.origin(in_ch.origin_y),
		.axis  (in_ch.axis_y),
		.offmag(offmag),
		.offneg(offneg),
		.root  (root),
		.sq    (sq_y),
		.point (pt_y),
		.org   (org_y)
	);

	pald_lane #(.W(W), .NW(NW)) u_lane_z (
		.clk   (clk),
		.en    (en),
		.origin(in_ch.origin_z),
		.axis  (in_ch.axis_z),
		.offmag(offmag),
		.offneg(offneg),
		.root  (root),
		.sq    (sq_z),
		.point (pt_z),
		.org   (org_z)
	);

	// squared length, scaled by 2^28 so the root keeps 14 extra fraction bits
	assign ssum = (2*W+2)'(sq_x) + (2*W+2)'(sq_y) + (2*W+2)'(sq_z);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= {ssum, {(2*EB){1'b0}}};
			deg_s3 <= ssum == '0;
		end
	end

	pald_sqrt #(.NW(NW)) u_sqrt (
		.clk (clk),
		.en  (en),
		.rad (rad_s3),
		.root(root)
	);

	// degenerate flag follows the lanes down to the merge
	for (genvar k = 0; k < DG; k++) begin : g_deg
		always_ff @(posedge clk) begin
			if (en) begin
				deg_d[k] <= (k == 0) ? deg_s3 : deg_d[(k == 0) ? 0 : k-1];
			end
		end
	end

	// merge: coincident points return the origin
	always_ff @(posedge clk) begin
		if (en) begin
			point_x_q <= deg_d[DG-1] ? org_x : pt_x;
			point_y_q <= deg_d[DG-1] ? org_y : pt_y;
			point_z_q <= deg_d[DG-1] ? org_z : pt_z;
			deg_q     <= deg_d[DG-1];
		end
	end

	assign out_ch.valid      = vld_q[LAT-1];
	assign out_ch.point_x    = point_x_q;
	assign out_ch.point_y    = point_y_q;
	assign out_ch.point_z    = point_z_q;
	assign out_ch.degenerate = deg_q;
endmodule

// ----- sv/pald_sqrt.sv -----
// pipelined integer square root, one result bit per stage
module pald_sqrt #(
	parameter int NW = pald_pkg::COORD_WIDTH + 15
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*NW-1:0] rad,
	output logic [NW-1:0]   root
);
	logic [NW:0]     rem_s  [NW];
	logic [NW-1:0]   root_s [NW];
	logic [2*NW-1:0] rad_s  [NW];

	for (genvar j = 0; j < NW; j++) begin : g_stage
		logic [NW:0]     rem_i;
		logic [NW-1:0]   root_i;
		logic [2*NW-1:0] rad_i;
		logic [NW+2:0]   cur;
		logic [NW+2:0]   trial;
		logic [NW+2:0]   diff;
		logic            ge;

		if (j == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad;
		end else begin : g_next
			assign rem_i  = rem_s[j-1];
			assign root_i = root_s[j-1];
			assign rad_i  = rad_s[j-1];
		end

		assign cur   = {rem_i, rad_i[2*NW-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};
		assign ge    = cur >= trial;
		assign diff  = cur - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? diff[NW:0] : cur[NW:0];
				root_s[j] <= {root_i[NW-2:0], ge};
				rad_s[j]  <= {rad_i[2*NW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[NW-1];
endmodule

// ----- sv/pald_div.sv -----
// pipelined restoring divider with quotient overflow detect
module pald_div #(
	parameter int NUMW = 2 * pald_pkg::COORD_WIDTH + 15,
	parameter int DENW = pald_pkg::COORD_WIDTH + 15,
	parameter int QW   = pald_pkg::COORD_WIDTH + 1
) (
	input  logic            clk,
	input  logic            en,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	output logic [QW-1:0]   quo,
	output logic            ovf
);
	localparam int HW = NUMW - QW;

	logic [HW-1:0]   num_hi;
	logic [DENW-1:0] rem_s0;
	logic [QW-1:0]   lo_s0;
	logic [DENW-1:0] den_s0;
	logic            ovf_s0;

	logic [DENW-1:0] rem_s [QW];
	logic [QW-1:0]   lo_s  [QW];
	logic [QW-1:0]   q_s   [QW];
	logic [DENW-1:0] den_s [QW];
	logic            ovf_s [QW];

	assign num_hi = num[NUMW-1:QW];

	// quotient beyond QW bits shows up as high part not below divisor
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s0 <= {{(DENW-HW){1'b0}}, num_hi} >= den;
			rem_s0 <= DENW'(num_hi);
			lo_s0  <= num[QW-1:0];
			den_s0 <= den;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DENW-1:0] rem_i;
		logic [QW-1:0]   lo_i;
		logic [QW-1:0]   q_i;
		logic [DENW-1:0] den_i;
		logic            ovf_i;
		logic [DENW:0]   cur;
		logic [DENW:0]   diff;
		logic            ge;

		if (k == 0) begin : g_first
			assign rem_i = rem_s0;
			assign lo_i  = lo_s0;
			assign q_i   = '0;
			assign den_i = den_s0;
			assign ovf_i = ovf_s0;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign lo_i  = lo_s[k-1];
			assign q_i   = q_s[k-1];
			assign den_i = den_s[k-1];
			assign ovf_i = ovf_s[k-1];
		end

		assign cur  = {rem_i, lo_i[QW-1]};
		assign ge   = cur >= {1'b0, den_i};
		assign diff = cur - {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DENW-1:0] : cur[DENW-1:0];
				lo_s[k]  <= {lo_i[QW-2:0], 1'b0};
				q_s[k]   <= {q_i[QW-2:0], ge};
				den_s[k] <= den_i;
				ovf_s[k] <= ovf_i;
			end
		end
	end

	assign quo = q_s[QW-1];
	assign ovf = ovf_s[QW-1];
endmodule

// ----- sv/pald_lane.sv -----
// one coordinate lane: difference, products, scaling divide and saturating add
module pald_lane #(
	parameter int W  = pald_pkg::COORD_WIDTH,
	parameter int NW = pald_pkg::COORD_WIDTH + 15
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] origin,
	input  logic signed [W-1:0] axis,
	input  logic [W-1:0]        offmag,
	input  logic                offneg,
	input  logic [NW-1:0]       root,
	output logic [2*W-1:0]      sq,
	output logic signed [W-1:0] point,
	output logic signed [W-1:0] org
);
	localparam int EB   = pald_pkg::EXTRA_BITS;
	localparam int NUMW = 2 * W + EB + 1;
	localparam int QW   = W + 1;
	localparam int OD   = NW + W + 3;

	logic [W:0]          dd;
	logic [W:0]          dmag;
	logic [W-1:0]        mag_s1;
	logic                neg_s1;
	logic signed [W-1:0] org_s1;
	logic [2*W-1:0]      sq_s2;
	logic [2*W-1:0]      prod_s2;
	logic                neg_s2;
	logic signed [W-1:0] org_s2;

	logic [2*W-1:0]      prod_d [NW+1];
	logic signed [W-1:0] org_d  [OD];
	logic                neg_d  [OD];

	logic [NUMW-1:0]     num;
	logic [QW-1:0]       quo;
	logic                ovf;
	logic signed [W+1:0] sum;
	logic signed [W-1:0] maxv;
	logic signed [W-1:0] minv;

	assign dd   = {axis[W-1], axis} - {origin[W-1], origin};
	assign dmag = dd[W] ? (~dd + 1'b1) : dd;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= dmag[W-1:0];
			neg_s1  <= offneg ^ dd[W];
			org_s1  <= origin;
			sq_s2   <= mag_s1 * mag_s1;
			prod_s2 <= offmag * mag_s1;
			neg_s2  <= neg_s1;
			org_s2  <= org_s1;
		end
	end

	// hold the product until the axis length comes out of the root
	for (genvar k = 0; k <= NW; k++) begin : g_prod
		always_ff @(posedge clk) begin
			if (en) begin
				prod_d[k] <= (k == 0) ? prod_s2 : prod_d[(k == 0) ? 0 : k-1];
			end
		end
	end

	for (genvar k = 0; k < OD; k++) begin : g_org
		always_ff @(posedge clk) begin
			if (en) begin
				org_d[k] <= (k == 0) ? org_s2 : org_d[(k == 0) ? 0 : k-1];
				neg_d[k] <= (k == 0) ? neg_s2 : neg_d[(k == 0) ? 0 : k-1];
			end
		end
	end

	// rounding: add half the divisor before the divide
	assign num = {1'b0, prod_d[NW], {EB{1'b0}}} + NUMW'(root[NW-1:1]);

	pald_div #(
		.NUMW(NUMW),
		.DENW(NW),
		.QW  (QW)
	) u_div (
		.clk(clk),
		.en (en),
		.num(num),
		.den(root),
		.quo(quo),
		.ovf(ovf)
	);

	assign maxv = {1'b0, {(W-1){1'b1}}};
	assign minv = {1'b1, {(W-1){1'b0}}};
	assign sum  = neg_d[OD-1] ?
		(W+2)'(org_d[OD-1]) - $signed({1'b0, quo}) :
		(W+2)'(org_d[OD-1]) + $signed({1'b0, quo});

	always_comb begin
		priority if (ovf) begin
			point = neg_d[OD-1] ? minv : maxv;
		end else if (sum > (W+2)'(maxv)) begin
			point = maxv;
		end else if (sum < (W+2)'(minv)) begin
			point = minv;
		end else begin
			point = sum[W-1:0];
		end
	end

	assign sq  = sq_s2;
	assign org = org_d[OD-1];
endmodule

// ----- verif/tb_top.sv -----
// testbench for point_at_distance_along_line: directed and random point pairs against a predictor
`timescale 1ns / 100ps

module tb_top;

	localparam int W         = pald_pkg::COORD_WIDTH;
	localparam int EB        = pald_pkg::EXTRA_BITS;
	localparam int LATENCY   = 2 * W + 21;
	localparam int WDOG_MAX  = 4000;
	localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic signed [W-1:0] ox, oy, oz;
		logic signed [W-1:0] ax, ay, az;
	} pair_t;

	typedef struct packed {
		logic signed [W-1:0] px, py, pz;
		logic                degenerate;
	} point_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cfg_we = 1'b0;
	logic [W-1:0]   cfg_wdata = '0;

	pald_in_if  #(.W(W)) in_ch ();
	pald_out_if #(.W(W)) out_ch ();

	point_at_distance_along_line #(.COORD_WIDTH(W)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// shadow of the offset register and the results still in flight
	logic signed [W-1:0] offset_shadow = '0;
	point_t              points_due[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int n_sent = 0, n_checked = 0, n_degen = 0, n_sat = 0, n_errors = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	initial begin
		in_ch.valid    = 1'b0;
		in_ch.origin_x = '0;
		in_ch.origin_y = '0;
		in_ch.origin_z = '0;
		in_ch.axis_x   = '0;
		in_ch.axis_y   = '0;
		in_ch.axis_z   = '0;
		out_ch.ready   = 1'b0;
	end

	// expected point for one pair under the given offset
	function automatic point_t predict_point(pair_t p, logic signed [W-1:0] off);
		longint      org[3], dif[3], res;
		logic [63:0] mag[3];
		logic [63:0] offmag, len, trial;
		logic [127:0] sumsq, num, quo;
		logic        neg;
		point_t      r;
		org[0] = p.ox; org[1] = p.oy; org[2] = p.oz;
		dif[0] = longint'(p.ax) - org[0];
		dif[1] = longint'(p.ay) - org[1];
		dif[2] = longint'(p.az) - org[2];
		sumsq = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = dif[i] < 0 ? -dif[i] : dif[i];
			sumsq = sumsq + {64'b0, mag[i]} * {64'b0, mag[i]};
		end
		if (sumsq == 0) begin
			r.px = p.ox; r.py = p.oy; r.pz = p.oz;
			r.degenerate = 1'b1;
			return r;
		end
		// length of the difference with extra fraction bits, bit by bit
		sumsq = sumsq << (2 * EB);
		len = '0;
		for (int b = 63; b >= 0; b--) begin
			trial = len | (64'd1 << b);
			if ({64'b0, trial} * {64'b0, trial} <= sumsq)
				len = trial;
		end
		offmag = off < 0 ? -longint'(off) : longint'(off);
		for (int i = 0; i < 3; i++) begin
			num = ({64'b0, offmag} * {64'b0, mag[i]}) << EB;
			quo = (num + {64'b0, len >> 1}) / {64'b0, len};
			if (quo > (128'd1 << 62))
				quo = 128'd1 << 62;
			neg = (off < 0) != (dif[i] < 0);
			res = neg ? org[i] - longint'(quo[63:0]) : org[i] + longint'(quo[63:0]);
			if (res > longint'(CMAX))
				res = CMAX;
			if (res < longint'(CMIN))
				res = CMIN;
			case (i)
				0: r.px = res[W-1:0];
				1: r.py = res[W-1:0];
				default: r.pz = res[W-1:0];
			endcase
		end
		r.degenerate = 1'b0;
		return r;
	endfunction

	// receiver: random back-pressure at the chosen rate
	always @(posedge clk)
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	// result checker: compare each transaction on out_ch with the oldest prediction
	always @(posedge clk) begin
		point_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (points_due.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h z=%h deg=%b", $time,
					out_ch.point_x, out_ch.point_y, out_ch.point_z, out_ch.degenerate);
				n_errors++;
			end else begin
				want = points_due.pop_front();
				n_checked++;
				if (want.px !== out_ch.point_x) begin
					$display("%0t: point_x expected %h actual %h", $time, want.px, out_ch.point_x);
					n_errors++;
				end
				if (want.py !== out_ch.point_y) begin
					$display("%0t: point_y expected %h actual %h", $time, want.py, out_ch.point_y);
					n_errors++;
				end
				if (want.pz !== out_ch.point_z) begin
					$display("%0t: point_z expected %h actual %h", $time, want.pz, out_ch.point_z);
					n_errors++;
				end
				if (want.degenerate !== out_ch.degenerate) begin
					$display("%0t: degenerate expected %b actual %b", $time,
						want.degenerate, out_ch.degenerate);
					n_errors++;
				end
			end
		end
	end

	// watchdog: too long without any transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_MAX) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time, points_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// one pair on in_ch; valid stays up if the next call follows at once
	task automatic send_pair(pair_t p);
		point_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.origin_x <= p.ox;
		in_ch.origin_y <= p.oy;
		in_ch.origin_z <= p.oz;
		in_ch.axis_x   <= p.ax;
		in_ch.axis_y   <= p.ay;
		in_ch.axis_z   <= p.az;
		want = predict_point(p, offset_shadow);
		do
			@(posedge clk);
		while (!in_ch.ready);
		points_due.push_back(want);
		n_sent++;
		if (want.degenerate)
			n_degen++;
		if (want.px == CMAX || want.px == CMIN || want.py == CMAX || want.py == CMIN ||
			want.pz == CMAX || want.pz == CMIN)
			n_sat++;
	endtask

	// let the pipeline empty, then idle further before any register write
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (points_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_offset(logic signed [W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		offset_shadow = v;
	endtask

	function automatic logic signed [W-1:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(3) == 0 ? CMAX : CMIN;
			2: return $signed($urandom_range(32'h0003_ffff)) - 32'sh0002_0000;
			default: return $signed($urandom_range(32'h07ff_ffff)) - 32'sh0400_0000;
		endcase
	endfunction

	function automatic logic signed [W-1:0] rand_delta(logic signed [W-1:0] o);
		case ($urandom_range(7))
			0: return o;
			1: return $urandom;
			2: return o + ($signed($urandom_range(8)) - 4);
			default: return o + ($signed($urandom_range(32'h001f_ffff)) - 32'sh0010_0000);
		endcase
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		p.ox = rand_coord();
		p.oy = rand_coord();
		p.oz = rand_coord();
		if ($urandom_range(19) == 0) begin
			// coincident points
			p.ax = p.ox; p.ay = p.oy; p.az = p.oz;
		end else begin
			p.ax = rand_delta(p.ox);
			p.ay = rand_delta(p.oy);
			p.az = rand_delta(p.oz);
		end
		return p;
	endfunction

	function automatic logic signed [W-1:0] rand_offset();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
			default: return $signed($urandom_range(32'h0fff_ffff)) - 32'sh0800_0000;
		endcase
	endfunction

	// directed: extremes of coordinates, offset extremes, coincident points, saturation
	task automatic test_directed();
		pair_t p;
		logic signed [W-1:0] offs[5];
		offs[0] = '0; offs[1] = CMAX; offs[2] = CMIN; offs[3] = 32'sh0001_0000; offs[4] = -1;
		for (int k = 0; k < 5; k++) begin
			drain_results();
			write_offset(offs[k]);
			// unit step along x
			p = '{ox: 0, oy: 0, oz: 0, ax: 32'sh0001_0000, ay: 0, az: 0};
			send_pair(p);
			// coincident points at the extremes
			p = '{ox: CMAX, oy: CMIN, oz: 0, ax: CMAX, ay: CMIN, az: 0};
			send_pair(p);
			// corner to corner, widest difference on every axis
			p = '{ox: CMIN, oy: CMIN, oz: CMIN, ax: CMAX, ay: CMAX, az: CMAX};
			send_pair(p);
			p = '{ox: CMAX, oy: CMIN, oz: CMAX, ax: CMIN, ay: CMAX, az: CMIN};
			send_pair(p);
			// smallest non-zero difference, off the origin at the positive edge
			p = '{ox: CMAX - 1, oy: 1, oz: -1, ax: CMAX, ay: 1, az: -1};
			send_pair(p);
		end
	endtask

	// random pairs under a run of offset settings, one register write per block
	task automatic test_random(int items, int blocks);
		for (int b = 0; b < blocks; b++) begin
			drain_results();
			case (b % 6)
				0: write_offset(CMAX);
				1: write_offset(CMIN);
				2: write_offset('0);
				default: write_offset(rand_offset());
			endcase
			for (int i = 0; i < items / blocks; i++) begin
				send_pair(rand_pair());
				// sender holds off until the pipeline has emptied, now and then
				if ($urandom_range(149) == 0)
					drain_results();
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 13;
		recv_idle_pct = 87;
		test_directed();
		test_random(400, 8);
		drain_results();

		send_idle_pct = 87;
		recv_idle_pct = 13;
		test_random(400, 8);
		drain_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(450, 9);
		drain_results();

		$display("covered %0d pairs, %0d checked: %0d coincident, %0d hitting the range limits",
			n_sent, n_checked, n_degen, n_sat);
		$display("offset swept through both extremes, zero and random values under three stall mixes");
		if (n_errors == 0 && points_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
